@@ hdl/double_buffered_transparent_framebuffer_top_assert.svh @@
// Assertion macros shared by the frame store RTL.
`ifndef DOUBLE_BUFFERED_TRANSPARENT_FRAMEBUFFER_TOP_ASSERT_SVH
`define DOUBLE_BUFFERED_TRANSPARENT_FRAMEBUFFER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBTF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dbtf_pkg.sv @@
// Package with the shared constants and types of the frame store.
`timescale 1ns / 1ps
`default_nettype none
package dbtf_pkg;

    localparam int unsigned PAGE_WORDS = 65536;
    localparam int unsigned PAGE_AW    = $clog2(PAGE_WORDS);
    localparam int unsigned RAM_AW     = PAGE_AW + 1;
    localparam int unsigned LANE_W     = 16;
    localparam int unsigned PIXEL_W    = 15;

    localparam logic [1:0] CTRL_ARM  = 2'd3;
    localparam logic [1:0] CTRL_FLIP = 2'd2;

    typedef enum logic [1:0] {
        FUNC_CPU_WRITE    = 2'd0,
        FUNC_CPU_READ     = 2'd1,
        FUNC_PAGE_CONTROL = 2'd2,
        FUNC_DISPLAY_READ = 2'd3
    } t_func;

    typedef struct packed {
        logic       xfer;
        logic [1:0] bits;
    } t_ctrl_req;

endpackage
`default_nettype wire

@@ hdl/dbtf_ram.sv @@
// Generic single-port RAM with two write lanes and a registered read.
`timescale 1ns / 1ps
`default_nettype none
module dbtf_ram #(
    parameter int unsigned ADDR_W = 17,
    parameter int unsigned LANE_W = 16
) (
    input  wire logic                  i_clk,
    input  wire logic [ADDR_W-1:0]     i_addr,
    input  wire logic [1:0]            i_we,
    input  wire logic [2*LANE_W-1:0]   i_wdata,
    input  wire logic                  i_re,
    output logic      [2*LANE_W-1:0]   o_rdata
);

    logic [2*LANE_W-1:0] mem [2**ADDR_W];
    logic [2*LANE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we[0]) begin
            mem[i_addr][LANE_W-1:0] <= i_wdata[LANE_W-1:0];
        end
        if (i_we[1]) begin
            mem[i_addr][2*LANE_W-1:LANE_W] <= i_wdata[2*LANE_W-1:LANE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hdl/dbtf_page_ctrl.sv @@
// Page select register that flips on the control sequence three then two.
`timescale 1ns / 1ps
`default_nettype none
`include "double_buffered_transparent_framebuffer_top_assert.svh"
module dbtf_page_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dbtf_pkg::t_ctrl_req i_req,
    output logic                   o_page,
    output logic                   o_page_next
);

    logic       r_page;
    logic       n_page;
    logic [1:0] r_last;
    logic [1:0] n_last;

    always_comb begin
        n_page = r_page;
        n_last = r_last;
        if (i_req.xfer) begin
            n_last = i_req.bits;
            if (r_last == dbtf_pkg::CTRL_ARM && i_req.bits == dbtf_pkg::CTRL_FLIP) begin
                n_page = ~r_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= 1'b0;
            r_last <= dbtf_pkg::CTRL_ARM;
        end else begin
            r_page <= n_page;
            r_last <= n_last;
        end
    end

    assign o_page      = r_page;
    assign o_page_next = n_page;

    `DBTF_ASSERT_NEXT(a_flip, i_clk, i_rst_n,
        i_req.xfer && r_last == dbtf_pkg::CTRL_ARM && i_req.bits == dbtf_pkg::CTRL_FLIP,
        r_page != $past(r_page), "page did not flip on the arm and flip sequence")
    `DBTF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !i_req.xfer,
        $stable(r_page) && $stable(r_last), "page state changed without a control transfer")
    `DBTF_ASSERT_NEXT(a_last, i_clk, i_rst_n, i_req.xfer,
        r_last == $past(i_req.bits), "last control bits not captured")

endmodule
`default_nettype wire

@@ hdl/double_buffered_transparent_framebuffer_top.sv @@
// Top level of the double-buffered transparent frame store.
// The store holds two pages of dbtf_pkg::PAGE_WORDS 32-bit words in one single-port RAM
// and takes one transfer every cycle, whatever its function, unless the output stalls.
// A result passes through the RAM read register, loaded when its item is accepted, and
// then the output register, which loads when the output can take it. The RAM port is the
// only shared resource and serves at most one access per item. Memory contents are
// undefined after reset and there is no clearing pass; the draw page starts at zero.
// Half-words with their top bit set are skipped on CPU writes.
`timescale 1ns / 1ps
`default_nettype none
`include "double_buffered_transparent_framebuffer_top_assert.svh"
module double_buffered_transparent_framebuffer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_word_address,
    input  wire logic [31:0] i_write_data,
    input  wire logic [1:0]  i_half_enable,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_read_data,
    output logic [14:0]      o_pixel_upper,
    output logic [14:0]      o_pixel_lower,
    output logic             o_draw_page
);

    dbtf_pkg::t_func     func;
    dbtf_pkg::t_ctrl_req ctrl_req;
    logic                in_xfer;
    logic                out_load;
    logic                page;
    logic                page_next;
    logic                rd_page;
    logic [1:0]          ram_we;
    logic                ram_re;
    logic [31:0]         ram_rdata;
    logic [dbtf_pkg::PAGE_AW-1:0] idx;

    logic                r_s1_valid;
    dbtf_pkg::t_func     r_s1_func;
    logic                r_s1_page;
    logic                r_out_valid;
    dbtf_pkg::t_func     r_out_func;
    logic [31:0]         r_out_data;
    logic [14:0]         r_out_upper;
    logic [14:0]         r_out_lower;
    logic                r_out_page;

    assign func     = dbtf_pkg::t_func'(i_func);
    assign out_load = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || out_load;
    assign in_xfer  = i_in_valid && o_in_ready;

    assign ctrl_req.xfer = in_xfer && func == dbtf_pkg::FUNC_PAGE_CONTROL;
    assign ctrl_req.bits = i_write_data[1:0];

    dbtf_page_ctrl u_page_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (ctrl_req),
        .o_page      (page),
        .o_page_next (page_next)
    );

    assign idx     = i_word_address[dbtf_pkg::PAGE_AW-1:0];
    assign rd_page = (func == dbtf_pkg::FUNC_DISPLAY_READ) ? ~page : page;
    assign ram_we[1] = in_xfer && func == dbtf_pkg::FUNC_CPU_WRITE && i_half_enable[1]
                       && !i_write_data[31];
    assign ram_we[0] = in_xfer && func == dbtf_pkg::FUNC_CPU_WRITE && i_half_enable[0]
                       && !i_write_data[15];
    assign ram_re  = in_xfer && (func == dbtf_pkg::FUNC_CPU_READ
                                 || func == dbtf_pkg::FUNC_DISPLAY_READ);

    dbtf_ram #(
        .ADDR_W (dbtf_pkg::RAM_AW),
        .LANE_W (dbtf_pkg::LANE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_addr  ({rd_page, idx}),
        .i_we    (ram_we),
        .i_wdata (i_write_data),
        .i_re    (ram_re),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_func <= func;
            r_s1_page <= page_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_func <= r_s1_func;
            r_out_page <= r_s1_page;
            unique case (r_s1_func)
                dbtf_pkg::FUNC_CPU_READ: begin
                    r_out_data  <= ram_rdata;
                    r_out_upper <= '0;
                    r_out_lower <= '0;
                end
                dbtf_pkg::FUNC_DISPLAY_READ: begin
                    r_out_data  <= ram_rdata;
                    r_out_upper <= ram_rdata[16 +: dbtf_pkg::PIXEL_W];
                    r_out_lower <= ram_rdata[0 +: dbtf_pkg::PIXEL_W];
                end
                default: begin
                    r_out_data  <= '0;
                    r_out_upper <= '0;
                    r_out_lower <= '0;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_out_data;
    assign o_pixel_upper = r_out_upper;
    assign o_pixel_lower = r_out_lower;
    assign o_draw_page   = r_out_page;

    `DBTF_ASSERT_SAME(a_drain, i_clk, i_rst_n, o_in_ready && r_s1_valid, out_load,
        "input taken while the read stage cannot drain")
    `DBTF_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !out_load, r_s1_valid,
        "read stage item lost while stalled")
    `DBTF_ASSERT_SAME(a_pix_zero, i_clk, i_rst_n,
        r_out_valid && r_out_func != dbtf_pkg::FUNC_DISPLAY_READ,
        r_out_upper == '0 && r_out_lower == '0, "pixels set on a non-display result")

endmodule
`default_nettype wire
